/* rtl/ikht_pkg.sv */
package ikht_pkg;

    localparam int SLOTS      = 1024;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS   = 11;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
    localparam int HASH_SHIFT = 16;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    localparam logic REG_EMPTY_KEY = 1'b0;
    localparam logic REG_DEAD_KEY  = 1'b1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        logic [CNT_BITS-1:0]   live_entries;
        logic [CNT_BITS-1:0]   dead_entries;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_HASH1, S_HASH2, S_HASH3,
        S_READ, S_WAIT, S_EVAL, S_DONE, S_INIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item
        logic hash1;
        logic hash2;
        logic hash3;      // set probe pointer from hash
        logic clr_step;   // write one empty mark, advance pointer
        logic clr_cnts;
        logic step;       // advance probe pointer
        logic commit;     // apply operation and build result
        logic fin;        // emit result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reserved;
        logic clr_last;
        logic end_walk;   // walk terminates at current slot
    } stat_t;

endpackage

/* rtl/ikht_ram.sv */
module ikht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ikht_ctrl.sv */
module ikht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     opcode,
    input  ikht_pkg::stat_t st,
    output ikht_pkg::cmd_t  cmd,
    output logic           busy
);

    ikht_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ikht_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ikht_pkg::S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ikht_pkg::S_IDLE;
                end
            end
            ikht_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = (opcode == ikht_pkg::OP_CLEAR) ? ikht_pkg::S_CLEAR
                                                                : ikht_pkg::S_HASH1;
                end
            end
            ikht_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    cmd.clr_cnts = 1'b1;
                    state_next = ikht_pkg::S_DONE;
                end
            end
            ikht_pkg::S_HASH1:
            begin
                cmd.hash1 = 1'b1;
                state_next = st.reserved ? ikht_pkg::S_DONE : ikht_pkg::S_HASH2;
            end
            ikht_pkg::S_HASH2:
            begin
                cmd.hash2 = 1'b1;
                state_next = ikht_pkg::S_HASH3;
            end
            ikht_pkg::S_HASH3:
            begin
                cmd.hash3 = 1'b1;
                state_next = ikht_pkg::S_READ;
            end
            ikht_pkg::S_READ:
            begin
                state_next = ikht_pkg::S_WAIT;
            end
            ikht_pkg::S_WAIT:
            begin
                state_next = ikht_pkg::S_EVAL;
            end
            ikht_pkg::S_EVAL:
            begin
                if (st.end_walk)
                begin
                    cmd.commit = 1'b1;
                    state_next = ikht_pkg::S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    state_next = ikht_pkg::S_READ;
                end
            end
            ikht_pkg::S_DONE:
            begin
                cmd.fin = 1'b1;
                state_next = ikht_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ikht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ikht_dp.sv */
module ikht_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ikht_pkg::cmd_t               cmd,
    input  ikht_pkg::item_t              item,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ikht_pkg::KEY_BITS-1:0] cfg_data,
    output ikht_pkg::stat_t              st,
    output ikht_pkg::result_t            res,
    output logic                         res_valid
);

    localparam int IB = ikht_pkg::IDX_BITS;
    localparam int CB = ikht_pkg::CNT_BITS;

    logic [31:0] empty_key_reg, dead_key_reg;
    ikht_pkg::item_t item_reg;
    logic [31:0] h_reg;
    logic [IB-1:0] ptr_reg;
    logic [IB:0]   visits_reg;
    logic [IB-1:0] first_dead_reg;
    logic          have_dead_reg;
    logic [CB-1:0] live_reg, dead_reg;
    logic          reserved_reg;
    ikht_pkg::result_t res_reg;
    logic          res_valid_reg;

    logic [1:0]  mark_rd;
    logic [31:0] key_rd;
    logic [ikht_pkg::VALUE_BITS-1:0] val_rd;
    logic        mark_we, key_we;
    logic [IB-1:0] waddr;
    logic [1:0]  mark_wd;

    logic [31:0] mix_in, mix_x;
    logic [IB-1:0] slot_hash;
    logic is_empty, is_dead, is_hit, last_visit;
    logic ins_ok;

    assign mix_in = cmd.hash1 ? item_reg.key : h_reg;
    assign mix_x  = (mix_in >> ikht_pkg::HASH_SHIFT) ^ mix_in;
    assign slot_hash = mix_x[IB-1:0];

    assign is_empty = (mark_rd == ikht_pkg::MARK_EMPTY);
    assign is_dead  = (mark_rd == ikht_pkg::MARK_DEAD);
    assign is_hit   = (mark_rd == ikht_pkg::MARK_LIVE) && (key_rd == item_reg.key);
    assign last_visit = (visits_reg == (IB+1)'(ikht_pkg::SLOTS - 1));

    assign st.end_walk = is_empty || is_hit || last_visit;
    assign st.clr_last = (ptr_reg == '1);
    assign st.reserved = reserved_reg;
    // free slot exists when the walk ends on empty or a tombstone has been seen
    assign ins_ok = is_empty || have_dead_reg || is_dead;

    always_comb
    begin
        mark_we = 1'b0;
        key_we  = 1'b0;
        waddr   = ptr_reg;
        mark_wd = ikht_pkg::MARK_LIVE;
        if (cmd.clr_step)
        begin
            mark_we = 1'b1;
            mark_wd = ikht_pkg::MARK_EMPTY;
        end
        else if (cmd.commit)
        begin
            unique case (item_reg.opcode)
                ikht_pkg::OP_INSERT:
                begin
                    if (is_hit)
                    begin
                        key_we = 1'b1;
                    end
                    else if (ins_ok)
                    begin
                        mark_we = 1'b1;
                        key_we  = 1'b1;
                        if (have_dead_reg)
                        begin
                            waddr = first_dead_reg;
                        end
                    end
                end
                ikht_pkg::OP_DELETE:
                begin
                    if (is_hit)
                    begin
                        mark_we = 1'b1;
                        mark_wd = ikht_pkg::MARK_DEAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    ikht_ram #(.WIDTH(2), .DEPTH(ikht_pkg::SLOTS)) u_marks (
        .clk(clk), .we(mark_we), .waddr(waddr), .wdata(mark_wd),
        .raddr(ptr_reg), .rdata(mark_rd)
    );
    ikht_ram #(.WIDTH(32), .DEPTH(ikht_pkg::SLOTS)) u_keys (
        .clk(clk), .we(key_we), .waddr(waddr), .wdata(item_reg.key),
        .raddr(ptr_reg), .rdata(key_rd)
    );
    ikht_ram #(.WIDTH(ikht_pkg::VALUE_BITS), .DEPTH(ikht_pkg::SLOTS)) u_vals (
        .clk(clk), .we(key_we), .waddr(waddr), .wdata(item_reg.value),
        .raddr(ptr_reg), .rdata(val_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_key_reg <= 32'hFFFF_FFFF;
            dead_key_reg  <= 32'hFFFF_FFFE;
            live_reg      <= '0;
            dead_reg      <= '0;
            res_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= cmd.fin;
            if (cfg_we)
            begin
                if (cfg_index == ikht_pkg::REG_EMPTY_KEY)
                begin
                    empty_key_reg <= cfg_data;
                end
                else
                begin
                    dead_key_reg <= cfg_data;
                end
            end
            if (cmd.clr_step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            else if (cmd.load)
            begin
                // a clear pass starts at slot zero
                ptr_reg <= '0;
            end
            else if (cmd.hash3)
            begin
                ptr_reg <= slot_hash;
            end
            else if (cmd.step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.clr_cnts)
            begin
                live_reg <= '0;
                dead_reg <= '0;
            end
            else if (cmd.commit)
            begin
                if (item_reg.opcode == ikht_pkg::OP_INSERT && !is_hit && ins_ok)
                begin
                    live_reg <= live_reg + 1'b1;
                    if (have_dead_reg || is_dead)
                    begin
                        dead_reg <= dead_reg - 1'b1;
                    end
                end
                else if (item_reg.opcode == ikht_pkg::OP_DELETE && is_hit)
                begin
                    live_reg <= live_reg - 1'b1;
                    dead_reg <= dead_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            reserved_reg <= (item.key == empty_key_reg) || (item.key == dead_key_reg);
            res_reg <= '0;
        end
        if (cmd.hash1 || cmd.hash2)
        begin
            h_reg <= mix_x * ikht_pkg::HASH_MUL;
        end
        if (cmd.hash1 && reserved_reg)
        begin
            res_reg.status <= ikht_pkg::ST_RESERVED;
        end
        if (cmd.hash3)
        begin
            visits_reg <= '0;
            have_dead_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            visits_reg <= visits_reg + 1'b1;
            if (is_dead && !have_dead_reg)
            begin
                have_dead_reg <= 1'b1;
                first_dead_reg <= ptr_reg;
            end
        end
        if (cmd.commit)
        begin
            if (item_reg.opcode == ikht_pkg::OP_INSERT)
            begin
                res_reg.status <= ins_ok || is_hit ? ikht_pkg::ST_OK : ikht_pkg::ST_FULL;
            end
            else if (is_hit)
            begin
                res_reg.found <= 1'b1;
                if (item_reg.opcode == ikht_pkg::OP_LOOKUP)
                begin
                    res_reg.value_out <= val_rd;
                end
            end
            else
            begin
                res_reg.status <= ikht_pkg::ST_NOTFOUND;
            end
        end
    end

    always_comb
    begin
        res = res_reg;
        res.live_entries = live_reg;
        res.dead_entries = dead_reg;
    end
    assign res_valid = res_valid_reg;

endmodule

/* rtl/int_key_hash_table.sv */
// channel | signals                         | transfer when
// --------+---------------------------------+------------------------------
// item    | start, busy, item (item_t)      | start && !busy at clk rise
// result  | done, result (result_t)         | done high, one cycle
// config  | cfg_we, cfg_index, cfg_data     | cfg_we high at clk rise
//
// an item passes three hash steps, then read, wait and evaluate for each probed
// slot since the memory read is registered, then the done state and the result
// register; a reserved key goes from the first hash step to the done state
// clear all writes an empty mark to every slot, then passes the done state
// after reset a pass over every slot empties the mark memory, busy stays high
// the result shows on done for one cycle; the receiver cannot stall
module int_key_hash_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ikht_pkg::item_t      item,
    output logic                 done,
    output ikht_pkg::result_t    result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

    // command and status between sequencer and datapath
    ikht_pkg::cmd_t  cmd;
    ikht_pkg::stat_t st;

    ikht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(item.opcode),
        .st(st), .cmd(cmd), .busy(busy)
    );

    ikht_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .st(st), .res(result), .res_valid(done)
    );

endmodule

/* test/int_key_hash_table_tb.sv */
`timescale 1ns / 100ps

module int_key_hash_table_tb;

    import ikht_pkg::*;

    // mirror of the hash table: slot contents, counts and reserved keys
    class table_scoreboard;
        logic [KEY_BITS-1:0]   slot_key [SLOTS];
        logic [VALUE_BITS-1:0] slot_val [SLOTS];
        logic [1:0]            slot_mark [SLOTS];
        logic [CNT_BITS-1:0]   live_cnt;
        logic [CNT_BITS-1:0]   dead_cnt;
        logic [31:0]           empty_key;
        logic [31:0]           dead_key;
        result_t               pending [$];
        int                    errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
                slot_mark[i] = MARK_EMPTY;
            live_cnt  = '0;
            dead_cnt  = '0;
            empty_key = 32'hFFFF_FFFF;
            dead_key  = 32'hFFFF_FFFE;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == REG_EMPTY_KEY)
                empty_key = data;
            else
                dead_key = data;
        endfunction

        // multiply-xorshift mix, two rounds
        function logic [31:0] mix(logic [31:0] k);
            k = ((k >> HASH_SHIFT) ^ k) * HASH_MUL;
            k = ((k >> HASH_SHIFT) ^ k) * HASH_MUL;
            return (k >> HASH_SHIFT) ^ k;
        endfunction

        // linear probe; free_slot == SLOTS means no slot to insert into
        function bit probe(logic [31:0] k, output int hit_slot, output int free_slot);
            int p;
            int first_dead;
            p          = int'(mix(k) % SLOTS);
            first_dead = SLOTS;
            hit_slot   = 0;
            free_slot  = SLOTS;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_mark[p] == MARK_EMPTY)
                begin
                    free_slot = (first_dead != SLOTS) ? first_dead : p;
                    return 0;
                end
                if (slot_mark[p] == MARK_DEAD)
                begin
                    if (first_dead == SLOTS)
                        first_dead = p;
                end
                else if (slot_key[p] == k)
                begin
                    hit_slot = p;
                    return 1;
                end
                p = (p + 1) % SLOTS;
            end
            free_slot = first_dead;
            return 0;
        endfunction

        // accepted item: apply it to the mirror and queue the expected result
        function void note_item(item_t it);
            result_t r;
            int hit_slot;
            int free_slot;
            r = '0;
            if (it.opcode == OP_CLEAR)
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_mark[i] = MARK_EMPTY;
                live_cnt = '0;
                dead_cnt = '0;
                r.status = ST_OK;
            end
            else if (it.key == empty_key || it.key == dead_key)
                r.status = ST_RESERVED;
            else if (it.opcode == OP_INSERT)
            begin
                if (probe(it.key, hit_slot, free_slot))
                    slot_val[hit_slot] = it.value;
                else if (free_slot >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    if (slot_mark[free_slot] == MARK_DEAD)
                        dead_cnt--;
                    slot_mark[free_slot] = MARK_LIVE;
                    slot_key[free_slot]  = it.key;
                    slot_val[free_slot]  = it.value;
                    live_cnt++;
                end
            end
            else if (probe(it.key, hit_slot, free_slot))
            begin
                r.found = 1'b1;
                if (it.opcode == OP_LOOKUP)
                    r.value_out = slot_val[hit_slot];
                else
                begin
                    slot_mark[hit_slot] = MARK_DEAD;
                    live_cnt--;
                    dead_cnt++;
                end
            end
            else
                r.status = ST_NOTFOUND;
            r.live_entries = live_cnt;
            r.dead_entries = dead_cnt;
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.value_out !== want.value_out ||
                got.live_entries !== want.live_entries ||
                got.dead_entries !== want.dead_entries)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    table_scoreboard sb;
    logic [31:0]     key_pool [64];

    int_key_hash_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // result monitor, results cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7:       n = $urandom_range(1, 3);
            8:             n = $urandom_range(4, 12);
            default:       n = $urandom_range(20, 80);
        endcase
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // present one item at the falling edge, hold it until the transfer;
    // busy is looked at between edges, so the next rising edge takes the item
    task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        start       = 1'b1;
        item.opcode = op;
        item.key    = k;
        item.value  = v;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_item(item);
        @(negedge clk);
        idle_gap();
    endtask

    // drain all results and let the block settle before touching registers
    task automatic wait_idle();
        start = 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random item biased toward a small key set so hits and tombstones pile up
    task automatic random_item();
        logic [1:0]  op;
        logic [31:0] k;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 42)
            op = OP_INSERT;
        else if (pick < 72)
            op = OP_LOOKUP;
        else if (pick < 99)
            op = OP_DELETE;
        else
            op = OP_CLEAR;
        pick = $urandom_range(19);
        if (pick < 15)
            k = key_pool[$urandom_range(63)];
        else if (pick < 17)
            k = sb.empty_key;
        else if (pick < 18)
            k = sb.dead_key;
        else
            k = $urandom;
        send_item(op, k, $urandom);
    endtask

    initial
    begin
        int n;
        logic [31:0] half;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_EMPTY_KEY;
        cfg_data  = '0;
        for (int i = 0; i < 64; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFD;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, reserved keys, update, tombstone reuse, clear
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0000, '0);
        send_item(OP_DELETE, 32'h0000_0000, '0);
        send_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FFFD, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
        send_item(OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_item(OP_LOOKUP, 32'h0000_0000, '0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h1);
        send_item(OP_LOOKUP, 32'hFFFF_FFFE, '0);
        send_item(OP_DELETE, 32'hFFFF_FFFE, '0);
        send_item(OP_DELETE, 32'h0000_0000, '0);
        send_item(OP_DELETE, 32'h0000_0000, '0);
        send_item(OP_LOOKUP, 32'h0000_0000, '0);
        send_item(OP_INSERT, 32'hFFFF_FFFD, 32'h5555_AAAA);
        send_item(OP_LOOKUP, 32'hFFFF_FFFD, '0);
        send_item(OP_INSERT, 32'h0000_0000, 32'h8000_0001);
        send_item(OP_LOOKUP, 32'h0000_0000, '0);
        send_item(OP_CLEAR, 32'h0000_0000, '0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFD, '0);

        // random phases, each under its own pair of reserved keys
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(REG_EMPTY_KEY, 32'h0000_0000);
                    write_reg(REG_DEAD_KEY, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_EMPTY_KEY, key_pool[2]);
                    write_reg(REG_DEAD_KEY, $urandom);
                end
                2:
                begin
                    // both registers equal, low extreme
                    write_reg(REG_EMPTY_KEY, 32'h0000_0000);
                    write_reg(REG_DEAD_KEY, 32'h0000_0000);
                end
                default:
                begin
                    write_reg(REG_EMPTY_KEY, 32'hFFFF_FFFF);
                    write_reg(REG_DEAD_KEY, 32'hFFFF_FFFE);
                end
            endcase
            // short random run under each pair, the full-table pass is long
            n = 5;
            for (int i = 0; i < n; i++)
                random_item();
        end

        // fill every slot, then probe a full table
        send_item(OP_CLEAR, '0, '0);
        for (int i = 0; i < SLOTS; i++)
            send_item(OP_INSERT, 32'h0001_0000 + i * 32'h9E37, $urandom);
        send_item(OP_INSERT, 32'h7777_0000, $urandom);
        send_item(OP_LOOKUP, 32'h7777_0000, '0);
        send_item(OP_INSERT, 32'h0001_0000, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0001_0000, '0);
        half = 32'h0001_0000 + (SLOTS / 2) * 32'h9E37;
        send_item(OP_DELETE, half, '0);
        send_item(OP_LOOKUP, 32'h7777_0001, '0);
        send_item(OP_INSERT, 32'h7777_0001, $urandom);
        send_item(OP_INSERT, 32'h7777_0002, $urandom);
        send_item(OP_LOOKUP, 32'h7777_0001, '0);
        send_item(OP_CLEAR, '0, '0);

        // drain and let the last transfer settle
        start = 1'b0;
        n = 0;
        while (sb.pending.size() != 0 && n < 20000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/ikht_pkg.sv
rtl/ikht_ram.sv
rtl/ikht_ctrl.sv
rtl/ikht_dp.sv
rtl/int_key_hash_table.sv
test/int_key_hash_table_tb.sv
